>>> rtl/md5he_pkg.sv
// ----------------------------------------------------------------------------
// md5he_pkg: shared types, constants and round functions
// Holds the MD5 initial values, the step constants, the rotate amounts, the
// message index schedule and the queue entry type used by the hash engine.
// ----------------------------------------------------------------------------
package md5he_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // One queued word: its slot in the block and whether it closes a message.
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  slot;
    logic        last;
  } qentry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
      4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
      4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
      4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  4'hf: r = 5'd21;
      default: r = 5'd7;
    endcase
    return r;
  endfunction

  // Message word picked by step i, modulo 16.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    g = 4'((lo << 1) + lo + 4'd5);
      default: g = 4'((lo << 3) - lo);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0]  rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

endpackage

>>> rtl/md5_hash_engine_top.sv
// ----------------------------------------------------------------------------
// md5_hash_engine_top: MD5 compression engine for pre-padded messages
// Input channel: one 32-bit little-endian message word per beat, with an end
// mark that counts only on the sixteenth word of a 64-byte block. Output
// channel: four digest beats A, B, C, D (index 0..3, last set on D), sent
// only after a block whose closing word carries the end mark.
// A four-entry queue and two 16-word bank buffers let words keep arriving
// while a block is compressed. The compressor passes through a start state,
// the MD5 steps and a fold state for each block, and a message end adds the
// digest beats. Once the back end is free, the first digest beat follows the
// start, step and fold states of the block whose closing word was accepted.
// Reset clears the word count, queue and banks and loads the MD5 initial
// values; the chaining words return to them after each digest.
// When the receiver stalls, the digest beat holds and compression of the
// next block waits; the input side keeps taking words until the queue and
// both banks are full, then raises in_stall_o.
// ----------------------------------------------------------------------------
module md5_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  digest_index_o,
  output logic        digest_last_o
);
  import md5he_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  qentry_t q_in;
  qentry_t q_out;

  md5he_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .message_word_i   (message_word_i),
    .end_of_message_i (end_of_message_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_entry_o        (q_in)
  );

  md5he_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  md5he_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digest_word_o  (digest_word_o),
    .digest_index_o (digest_index_o),
    .digest_last_o  (digest_last_o)
  );

endmodule

>>> rtl/md5he_front.sv
// ----------------------------------------------------------------------------
// md5he_front: word intake and classification
// Accepts message words, tags each with its slot in the 16-word block and
// marks the block-closing word of a message, then pushes it to the queue.
// ----------------------------------------------------------------------------
module md5he_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       message_word_i,
  input  logic              end_of_message_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output md5he_pkg::qentry_t q_entry_o
);
  import md5he_pkg::*;

  logic [3:0] cnt_q, cnt_d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_entry_o.word = message_word_i;
    q_entry_o.slot = cnt_q;
    // Honor the end mark only on the block's final word.
    q_entry_o.last = end_of_message_i & (cnt_q == 4'hf);
    cnt_d = q_push_o ? cnt_q + 4'd1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/md5he_queue.sv
// ----------------------------------------------------------------------------
// md5he_queue: short word queue
// Small FIFO between intake and compression so each side stalls on its own.
// ----------------------------------------------------------------------------
module md5he_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  md5he_pkg::qentry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output md5he_pkg::qentry_t entry_o
);
  import md5he_pkg::*;

  qentry_t        mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   count_q, count_d;

  assign full_o  = (count_q == (QAW+1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/md5he_back.sv
// ----------------------------------------------------------------------------
// md5he_back: block buffer, compression and digest output
// Fills two 16-word banks from the queue, runs the 64 MD5 steps one per
// cycle on a full bank, folds the result into the chaining words and
// streams the digest when the block closes a message.
// ----------------------------------------------------------------------------
module md5he_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  md5he_pkg::qentry_t q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        digest_word_o,
  output logic [1:0]         digest_index_o,
  output logic               digest_last_o
);
  import md5he_pkg::*;

  back_state_e state_q, state_d;
  logic [31:0] blk_mem_q [32];
  logic [1:0]  bank_full_q, bank_full_d;
  logic [1:0]  bank_last_q, bank_last_d;
  logic        fill_bank_q, fill_bank_d;
  logic        cmp_bank_q, cmp_bank_d;
  logic        last_q, last_d;
  logic [5:0]  step_q, step_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] wrk_q [4];
  logic [31:0] wrk_d [4];
  logic [4:0]  rd_addr_w;
  logic [31:0] msg_q;
  logic [31:0] sum_w;
  logic [31:0] new_b_w;

  assign q_pop_o = q_valid_i & ~bank_full_q[fill_bank_q];

  assign out_valid_o    = (state_q == ST_EMIT);
  assign digest_word_o  = chain_q[idx_q];
  assign digest_index_o = idx_q;
  assign digest_last_o  = (idx_q == 2'd3);

  // Fetch the word for the next step; the start cycle fetches step 0's word.
  assign rd_addr_w = (state_q == ST_RUN) ? {cmp_bank_q, msg_index(step_q + 6'd1)}
                                         : {cmp_bank_q, 4'd0};

  // One MD5 step: a + f + K + M, rotate, add b.
  always_comb begin
    sum_w   = wrk_q[0] + round_fn(step_q[5:4], wrk_q[1], wrk_q[2], wrk_q[3])
              + step_const(step_q) + msg_q;
    new_b_w = wrk_q[1] + rotl32(sum_w, rot_amount(step_q));
  end

  always_comb begin
    state_d     = state_q;
    bank_full_d = bank_full_q;
    bank_last_d = bank_last_q;
    fill_bank_d = fill_bank_q;
    cmp_bank_d  = cmp_bank_q;
    last_d      = last_q;
    step_d      = step_q;
    idx_d       = idx_q;
    chain_d     = chain_q;
    wrk_d       = wrk_q;

    // Fill side: close the bank on its sixteenth word.
    if (q_pop_o && q_entry_i.slot == 4'hf) begin
      bank_full_d[fill_bank_q] = 1'b1;
      bank_last_d[fill_bank_q] = q_entry_i.last;
      fill_bank_d              = ~fill_bank_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (bank_full_q[cmp_bank_q]) begin
          wrk_d   = chain_q;
          last_d  = bank_last_q[cmp_bank_q];
          step_d  = 6'd0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        wrk_d[0] = wrk_q[3];
        wrk_d[1] = new_b_w;
        wrk_d[2] = wrk_q[1];
        wrk_d[3] = wrk_q[2];
        step_d   = step_q + 6'd1;
        if (step_q == 6'd63) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int k = 0; k < 4; k++) begin
          chain_d[k] = chain_q[k] + wrk_q[k];
        end
        // Release the bank to the fill side.
        bank_full_d[cmp_bank_q] = 1'b0;
        cmp_bank_d = ~cmp_bank_q;
        idx_d      = 2'd0;
        state_d    = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            chain_d[0] = IV_A;
            chain_d[1] = IV_B;
            chain_d[2] = IV_C;
            chain_d[3] = IV_D;
            state_d    = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      blk_mem_q[{fill_bank_q, q_entry_i.slot}] <= q_entry_i.word;
    end
    msg_q <= blk_mem_q[rd_addr_w];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_full_q <= 2'b00;
      bank_last_q <= 2'b00;
      fill_bank_q <= 1'b0;
      cmp_bank_q  <= 1'b0;
      last_q      <= 1'b0;
      step_q      <= 6'd0;
      idx_q       <= 2'd0;
      chain_q[0]  <= IV_A;
      chain_q[1]  <= IV_B;
      chain_q[2]  <= IV_C;
      chain_q[3]  <= IV_D;
      for (int k = 0; k < 4; k++) begin
        wrk_q[k] <= 32'd0;
      end
    end else begin
      state_q     <= state_d;
      bank_full_q <= bank_full_d;
      bank_last_q <= bank_last_d;
      fill_bank_q <= fill_bank_d;
      cmp_bank_q  <= cmp_bank_d;
      last_q      <= last_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      chain_q     <= chain_d;
      wrk_q       <= wrk_d;
    end
  end

endmodule
